FILE: rtl/core/pbsd_pkg.sv
// ----------------------------------------------------------------------------
// pbsd_pkg
// Shared types and constants for the blended segment distance unit.
// ----------------------------------------------------------------------------
package pbsd_pkg;

    localparam int DIST_W = 33;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef logic [1:0] t_region;

    localparam t_region REG_BEFORE = 2'd0;
    localparam t_region REG_ALONG  = 2'd1;
    localparam t_region REG_BEYOND = 2'd2;

endpackage

FILE: rtl/core/pbsd_div_cell.sv
// ----------------------------------------------------------------------------
// pbsd_div_cell
// One restoring division step: yields one quotient bit per cycle while i_en is high.
// ----------------------------------------------------------------------------
module pbsd_div_cell #(
    parameter int W     = 8,
    parameter int QW    = 4,
    parameter bit FIRST = 1'b0
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [W-1:0]  i_rem,
    input  logic [W-1:0]  i_den,
    input  logic [QW-1:0] i_q,
    output logic [W-1:0]  o_rem,
    output logic [W-1:0]  o_den,
    output logic [QW-1:0] o_q
);

    logic [W:0]    w_t;
    logic [W:0]    w_diff;
    logic          w_ge;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_den;
    logic [QW-1:0] r_q;

    always_comb begin
        w_t    = FIRST ? {1'b0, i_rem} : {i_rem, 1'b0};
        w_ge   = (w_t >= {1'b0, i_den});
        w_diff = w_t - {1'b0, i_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= w_ge ? w_diff[W-1:0] : w_t[W-1:0];
            r_den <= i_den;
            r_q   <= {i_q[QW-2:0], w_ge};
        end
    end

    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_q   = r_q;

endmodule

FILE: rtl/core/pbsd_sqrt_cell.sv
// ----------------------------------------------------------------------------
// pbsd_sqrt_cell
// One digit-by-digit square root step: yields one root bit per cycle while i_en is high.
// ----------------------------------------------------------------------------
module pbsd_sqrt_cell #(
    parameter int RW = 8,
    parameter int SW = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW+1:0] i_rem,
    input  logic [RW-1:0] i_root,
    input  logic [SW-1:0] i_rad,
    output logic [RW+1:0] o_rem,
    output logic [RW-1:0] o_root,
    output logic [SW-1:0] o_rad
);

    logic [RW+1:0] w_sh;
    logic [RW+1:0] w_trial;
    logic          w_ge;
    logic [RW+1:0] r_rem;
    logic [RW-1:0] r_root;
    logic [SW-1:0] r_rad;

    always_comb begin
        w_sh    = {i_rem[RW-1:0], i_rad[SW-1:SW-2]};
        w_trial = {i_root, 2'b01};
        w_ge    = (w_sh >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_ge ? (w_sh - w_trial) : w_sh;
            r_root <= {i_root[RW-2:0], w_ge};
            r_rad  <= {i_rad[SW-3:0], 2'b00};
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;

endmodule

FILE: rtl/core/point_to_blended_segment_dist_unit.sv
// ----------------------------------------------------------------------------
// point_to_blended_segment_dist_unit
// The datapath runs through a divider cell chain (FRAC_BITS+1 cells) and a
// root chain (COORD_WIDTH+2 cells) before the output register.
// Throughput: one beat per cycle; the whole pipeline holds while a result
// waits at the output register.
// Reset clears all valid bits; datapath registers are not reset.
// ----------------------------------------------------------------------------
module point_to_blended_segment_dist_unit
    import pbsd_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_query_x,
    input  logic signed [COORD_WIDTH-1:0] i_query_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_orig_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_orig_y,
    input  logic signed [COORD_WIDTH-1:0] i_start_moved_x,
    input  logic signed [COORD_WIDTH-1:0] i_start_moved_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_orig_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_orig_y,
    input  logic signed [COORD_WIDTH-1:0] i_end_moved_x,
    input  logic signed [COORD_WIDTH-1:0] i_end_moved_y,
    input  logic [FRAC_BITS:0]            i_blend,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [DIST_W-1:0]             o_distance,
    output logic [1:0]                    o_region,
    output logic                          o_degenerate
);

    localparam int CW   = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int QW   = F + 1;
    localparam int DW   = CW + 1;
    localparam int PW   = CW + QW;
    localparam int MW   = DW + QW;
    localparam int L2W  = 2 * CW + 2;
    localparam int DOTW = L2W + 1;
    localparam int SQW  = 2 * DW;
    localparam int RW   = CW + 2;
    localparam int SW   = 2 * RW;
    localparam int CMPW = (RW > DIST_W) ? RW : DIST_W;
    localparam logic [QW-1:0] ONE = QW'(1) << F;

    logic en;
    assign en = !o_valid || i_ready;
    assign o_ready = en;

    // stage 1: endpoint offsets scaled by blend
    logic signed [CW-1:0] w_o [4];
    logic signed [CW-1:0] w_m [4];
    logic signed [DW-1:0] w_diff [4];
    logic [DW-1:0]        w_mag [4];
    logic [QW-1:0]        w_t;

    assign w_o[0] = i_start_orig_x;
    assign w_o[1] = i_start_orig_y;
    assign w_o[2] = i_end_orig_x;
    assign w_o[3] = i_end_orig_y;
    assign w_m[0] = i_start_moved_x;
    assign w_m[1] = i_start_moved_y;
    assign w_m[2] = i_end_moved_x;
    assign w_m[3] = i_end_moved_y;
    assign w_t    = (i_blend > ONE) ? ONE : i_blend;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_diff[k] = DW'(w_m[k]) - DW'(w_o[k]);
            w_mag[k]  = w_diff[k][DW-1] ? DW'(-w_diff[k]) : DW'(w_diff[k]);
        end
    end

    logic                 r1_v;
    logic signed [CW-1:0] r1_o [4];
    logic                 r1_neg [4];
    logic [PW-1:0]        r1_p [4];
    logic signed [CW-1:0] r1_qx, r1_qy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r1_o[k]   <= w_o[k];
                r1_neg[k] <= w_diff[k][DW-1];
                r1_p[k]   <= PW'(w_mag[k][CW-1:0]) * PW'(w_t);
            end
            r1_qx <= i_query_x;
            r1_qy <= i_query_y;
        end
    end

    // stage 2: blended endpoints
    logic [DW-1:0]        w_pt [4];
    logic                 r2_v;
    logic signed [CW-1:0] r2_p [4];
    logic signed [CW-1:0] r2_qx, r2_qy;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_pt[k] = r1_neg[k] ? DW'(r1_o[k]) - DW'(r1_p[k][F +: CW])
                                : DW'(r1_o[k]) + DW'(r1_p[k][F +: CW]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            for (int k = 0; k < 4; k++) begin
                r2_p[k] <= w_pt[k][CW-1:0];
            end
            r2_qx <= r1_qx;
            r2_qy <= r1_qy;
        end
    end

    // stage 3: direction and query offset
    logic                 r3_v;
    logic signed [CW-1:0] r3_ax, r3_ay, r3_qx, r3_qy;
    logic signed [DW-1:0] r3_dx, r3_dy, r3_ux, r3_uy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
        if (en) begin
            r3_ax <= r2_p[0];
            r3_ay <= r2_p[1];
            r3_qx <= r2_qx;
            r3_qy <= r2_qy;
            r3_dx <= DW'(r2_p[2]) - DW'(r2_p[0]);
            r3_dy <= DW'(r2_p[3]) - DW'(r2_p[1]);
            r3_ux <= DW'(r2_qx) - DW'(r2_p[0]);
            r3_uy <= DW'(r2_qy) - DW'(r2_p[1]);
        end
    end

    // stage 4: products
    logic                  r4_v;
    logic signed [CW-1:0]  r4_ax, r4_ay, r4_qx, r4_qy;
    logic signed [DW-1:0]  r4_dx, r4_dy;
    logic signed [L2W-1:0] r4_xx, r4_yy, r4_ux, r4_uy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
        if (en) begin
            r4_ax <= r3_ax;
            r4_ay <= r3_ay;
            r4_qx <= r3_qx;
            r4_qy <= r3_qy;
            r4_dx <= r3_dx;
            r4_dy <= r3_dy;
            r4_xx <= L2W'(r3_dx) * L2W'(r3_dx);
            r4_yy <= L2W'(r3_dy) * L2W'(r3_dy);
            r4_ux <= L2W'(r3_ux) * L2W'(r3_dx);
            r4_uy <= L2W'(r3_uy) * L2W'(r3_dy);
        end
    end

    // stage 5: length, dot product and region
    logic [L2W-1:0]         w_len2;
    logic signed [DOTW-1:0] w_dot;
    t_region                w_reg;
    logic                   r5_v;
    logic [L2W-1:0]         r5_len2, r5_rem;
    t_region                r5_reg;
    logic                   r5_deg;
    logic signed [CW-1:0]   r5_ax, r5_ay, r5_qx, r5_qy;
    logic signed [DW-1:0]   r5_dx, r5_dy;

    always_comb begin
        w_len2 = r4_xx + r4_yy;
        w_dot  = DOTW'(r4_ux) + DOTW'(r4_uy);
        if (w_dot[DOTW-1]) begin
            w_reg = REG_BEFORE;
        end else if (w_dot > $signed({1'b0, w_len2})) begin
            w_reg = REG_BEYOND;
        end else begin
            w_reg = REG_ALONG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
        if (en) begin
            r5_len2 <= w_len2;
            r5_rem  <= w_dot[L2W-1:0];
            r5_reg  <= w_reg;
            r5_deg  <= (w_len2 == '0);
            r5_ax   <= r4_ax;
            r5_ay   <= r4_ay;
            r5_qx   <= r4_qx;
            r5_qy   <= r4_qy;
            r5_dx   <= r4_dx;
            r5_dy   <= r4_dy;
        end
    end

    // divider chain: one quotient bit per cell
    logic [L2W-1:0]       w_drem [QW+1];
    logic [L2W-1:0]       w_dden [QW+1];
    logic [QW-1:0]        w_dq   [QW+1];
    logic                 r_dv   [QW];
    t_region              r_dreg [QW];
    logic                 r_ddeg [QW];
    logic signed [CW-1:0] r_dax  [QW];
    logic signed [CW-1:0] r_day  [QW];
    logic signed [CW-1:0] r_dqx  [QW];
    logic signed [CW-1:0] r_dqy  [QW];
    logic signed [DW-1:0] r_ddx  [QW];
    logic signed [DW-1:0] r_ddy  [QW];

    assign w_drem[0] = r5_rem;
    assign w_dden[0] = r5_len2;
    assign w_dq[0]   = '0;

    for (genvar g = 0; g < QW; g++) begin : g_div
        pbsd_div_cell #(
            .W     (L2W),
            .QW    (QW),
            .FIRST (g == 0)
        ) u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_rem (w_drem[g]),
            .i_den (w_dden[g]),
            .i_q   (w_dq[g]),
            .o_rem (w_drem[g+1]),
            .o_den (w_dden[g+1]),
            .o_q   (w_dq[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_dv[k] <= 1'b0;
            end
        end else if (en) begin
            r_dv[0] <= r5_v;
            for (int k = 1; k < QW; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
        end
        if (en) begin
            r_dreg[0] <= r5_reg;
            r_ddeg[0] <= r5_deg;
            r_dax[0]  <= r5_ax;
            r_day[0]  <= r5_ay;
            r_dqx[0]  <= r5_qx;
            r_dqy[0]  <= r5_qy;
            r_ddx[0]  <= r5_dx;
            r_ddy[0]  <= r5_dy;
            for (int k = 1; k < QW; k++) begin
                r_dreg[k] <= r_dreg[k-1];
                r_ddeg[k] <= r_ddeg[k-1];
                r_dax[k]  <= r_dax[k-1];
                r_day[k]  <= r_day[k-1];
                r_dqx[k]  <= r_dqx[k-1];
                r_dqy[k]  <= r_dqy[k-1];
                r_ddx[k]  <= r_ddx[k-1];
                r_ddy[k]  <= r_ddy[k-1];
            end
        end
    end

    // stage 6: scale direction by delta
    logic [DW-1:0]        w_mdx, w_mdy;
    logic                 r6_v;
    t_region              r6_reg;
    logic                 r6_deg;
    logic signed [CW-1:0] r6_ax, r6_ay, r6_qx, r6_qy;
    logic signed [DW-1:0] r6_dx, r6_dy;
    logic [MW-1:0]        r6_px, r6_py;

    assign w_mdx = r_ddx[QW-1][DW-1] ? DW'(-r_ddx[QW-1]) : DW'(r_ddx[QW-1]);
    assign w_mdy = r_ddy[QW-1][DW-1] ? DW'(-r_ddy[QW-1]) : DW'(r_ddy[QW-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r_dv[QW-1];
        end
        if (en) begin
            r6_reg <= r_dreg[QW-1];
            r6_deg <= r_ddeg[QW-1];
            r6_ax  <= r_dax[QW-1];
            r6_ay  <= r_day[QW-1];
            r6_qx  <= r_dqx[QW-1];
            r6_qy  <= r_dqy[QW-1];
            r6_dx  <= r_ddx[QW-1];
            r6_dy  <= r_ddy[QW-1];
            r6_px  <= MW'(w_mdx) * MW'(w_dq[QW]);
            r6_py  <= MW'(w_mdy) * MW'(w_dq[QW]);
        end
    end

    // stage 7: foot point and error vector
    logic signed [DW-1:0] w_fx, w_fy, w_ex, w_ey;
    logic                 r7_v;
    t_region              r7_reg;
    logic                 r7_deg;
    logic [DW-1:0]        r7_ex, r7_ey;

    always_comb begin
        case (r6_reg)
            REG_BEFORE: begin
                w_fx = DW'(r6_ax);
                w_fy = DW'(r6_ay);
            end
            REG_BEYOND: begin
                w_fx = DW'(r6_ax) + r6_dx;
                w_fy = DW'(r6_ay) + r6_dy;
            end
            default: begin
                w_fx = r6_dx[DW-1] ? DW'(r6_ax) - $signed(r6_px[F +: DW])
                                   : DW'(r6_ax) + $signed(r6_px[F +: DW]);
                w_fy = r6_dy[DW-1] ? DW'(r6_ay) - $signed(r6_py[F +: DW])
                                   : DW'(r6_ay) + $signed(r6_py[F +: DW]);
            end
        endcase
        w_ex = w_fx - DW'(r6_qx);
        w_ey = w_fy - DW'(r6_qy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r6_v;
        end
        if (en) begin
            r7_reg <= r6_reg;
            r7_deg <= r6_deg;
            r7_ex  <= w_ex[DW-1] ? DW'(-w_ex) : DW'(w_ex);
            r7_ey  <= w_ey[DW-1] ? DW'(-w_ey) : DW'(w_ey);
        end
    end

    // stages 8 and 9: squared distance
    logic           r8_v, r9_v;
    t_region        r8_reg, r9_reg;
    logic           r8_deg, r9_deg;
    logic [SQW-1:0] r8_sx, r8_sy;
    logic [SW-1:0]  r9_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else if (en) begin
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
        if (en) begin
            r8_reg <= r7_reg;
            r8_deg <= r7_deg;
            r8_sx  <= SQW'(r7_ex) * SQW'(r7_ex);
            r8_sy  <= SQW'(r7_ey) * SQW'(r7_ey);
            r9_reg <= r8_reg;
            r9_deg <= r8_deg;
            r9_sum <= SW'(r8_sx) + SW'(r8_sy);
        end
    end

    // root chain: one root bit per cell
    logic [RW+1:0] w_srem  [RW+1];
    logic [RW-1:0] w_sroot [RW+1];
    logic [SW-1:0] w_srad  [RW+1];
    logic          r_sv    [RW];
    t_region       r_sreg  [RW];
    logic          r_sdeg  [RW];

    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;
    assign w_srad[0]  = r9_sum;

    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        pbsd_sqrt_cell #(
            .RW (RW),
            .SW (SW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (w_srem[g]),
            .i_root (w_sroot[g]),
            .i_rad  (w_srad[g]),
            .o_rem  (w_srem[g+1]),
            .o_root (w_sroot[g+1]),
            .o_rad  (w_srad[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RW; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else if (en) begin
            r_sv[0] <= r9_v;
            for (int k = 1; k < RW; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
        end
        if (en) begin
            r_sreg[0] <= r9_reg;
            r_sdeg[0] <= r9_deg;
            for (int k = 1; k < RW; k++) begin
                r_sreg[k] <= r_sreg[k-1];
                r_sdeg[k] <= r_sdeg[k-1];
            end
        end
    end

    // output register
    logic [CMPW-1:0]   w_root;
    logic [DIST_W-1:0] w_dist;
    logic              r_ov;
    logic [DIST_W-1:0] r_dist;
    t_region           r_reg;
    logic              r_deg;

    assign w_root = CMPW'(w_sroot[RW]);
    assign w_dist = (w_root > CMPW'(DIST_MAX)) ? DIST_MAX : w_root[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_sv[RW-1];
        end
        if (en) begin
            r_deg  <= r_sdeg[RW-1];
            r_reg  <= r_sdeg[RW-1] ? REG_ALONG : r_sreg[RW-1];
            r_dist <= r_sdeg[RW-1] ? '0 : w_dist;
        end
    end

    assign o_valid      = r_ov;
    assign o_distance   = r_dist;
    assign o_region     = r_reg;
    assign o_degenerate = r_deg;

    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_distance == '0 && o_region == REG_ALONG)
        else $error("degenerate beat with nonzero distance or wrong region");

    a_region_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_region == REG_BEFORE || o_region == REG_ALONG
                    || o_region == REG_BEYOND)
        else $error("region code out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

endmodule
